/* sv/simc_pkg.sv */
// types and constants shared by the scan interval mode controller
package simc_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int STATE_WIDTH = 3;
   localparam int EVENT_WIDTH = 3;
   localparam int PRESENCE_WIDTH = 2;
   localparam int COMMAND_WIDTH = 2;
   localparam int SETTING_WIDTH = 2;
   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [EVENT_WIDTH-1:0] {
      EV_STARTUP_DONE    = 3'd0,
      EV_SETTING_CHANGED = 3'd1,
      EV_AGENT_INTERVAL  = 3'd2,
      EV_COMMAND_DONE    = 3'd3,
      EV_AGGR_START      = 3'd4,
      EV_AGGR_STOP       = 3'd5,
      EV_INIT            = 3'd6
   } event_type;

   typedef enum logic [1:0] {
      PT_NONE       = 2'd0,
      PT_OFF        = 2'd1,
      PT_ON         = 2'd2,
      PT_AUTO_AGENT = 2'd3
   } target_type;

   localparam logic [PRESENCE_WIDTH-1:0] PRES_STARTING = 2'd0;
   localparam logic [PRESENCE_WIDTH-1:0] PRES_PRESENT  = 2'd1;

   localparam logic [COMMAND_WIDTH-1:0] CMD_NONE  = 2'd0;
   localparam logic [COMMAND_WIDTH-1:0] CMD_START = 2'd1;
   localparam logic [COMMAND_WIDTH-1:0] CMD_STOP  = 2'd2;

   localparam logic [SETTING_WIDTH-1:0] SET_NEVER = 2'd0;
   localparam logic [SETTING_WIDTH-1:0] SET_FIXED = 2'd1;
   localparam logic [SETTING_WIDTH-1:0] SET_AUTO  = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SETTING_MODE     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIXED_INTERVAL   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCANNING_ENABLED = 2'd2;

   typedef struct packed {
      logic publish;
      logic cancel_scan;
      logic scan_now;
   } refresh_flags_type;

endpackage

/* sv/simc_refresh.sv */
// used interval recomputation and the scan actions that follow from it
module simc_refresh #(
   parameter int INTERVAL_WIDTH = 32
) (
   input  logic                            scanning_enabled,
   input  logic [INTERVAL_WIDTH-1:0]       aggr_interval,
   input  logic [INTERVAL_WIDTH-1:0]       normal_interval,
   input  logic [INTERVAL_WIDTH-1:0]       old_used,
   output logic [INTERVAL_WIDTH-1:0]       new_used,
   output simc_pkg::refresh_flags_type     flags
);
   import simc_pkg::*;

   localparam logic [INTERVAL_WIDTH-1:0] NO_SCAN = '1;

   logic shorter;

   always_comb begin
      if (!scanning_enabled) begin
         new_used = NO_SCAN;
      end else if (aggr_interval < normal_interval) begin
         new_used = aggr_interval;
      end else begin
         new_used = normal_interval;
      end
   end

   assign shorter = (new_used < old_used);
   assign flags.publish = (new_used != old_used);
   assign flags.cancel_scan = (new_used == NO_SCAN) || shorter;
   assign flags.scan_now = (new_used != NO_SCAN) && shorter;

endmodule

/* sv/scan_interval_mode_controller_core.sv */
// top level of the background scan interval mode controller
//
// usage
//    req_* carries one event per transfer (valid/stall); rsp_* returns exactly
//    one result per event, in order, with the resulting state, the published
//    interval (0 for no scanning) and the actions to take.
//    csr_* writes the setting mode, fixed interval and scanning enable; the
//    port is always ready and a write with an unused index is dropped.
//    an event is held in an input register, decoded combinationally against
//    the controller state and then loaded into the result register, which
//    offers it on rsp_*; one event is taken per cycle while the result
//    register is not held by rsp_stall.
//    the controller state advances as an event moves into the result register.
//    while rsp_stall is high the result holds; req_stall then rises once the
//    input register is also full, so nothing is dropped.
//    reset puts the controller in init with no pending target, all intervals
//    at no scanning, the registers at never, fixed 1 and scanning disabled,
//    and both channels empty.
module scan_interval_mode_controller_core #(
   parameter int INTERVAL_WIDTH = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [simc_pkg::EVENT_WIDTH-1:0]         req_mode,
   input  logic                                     req_status_ok,
   input  logic [simc_pkg::PRESENCE_WIDTH-1:0]      req_agent_presence,
   input  logic [simc_pkg::VALUE_WIDTH-1:0]         req_auto_interval,
   input  logic [simc_pkg::VALUE_WIDTH-1:0]         req_aggressive_interval,
   input  logic [simc_pkg::VALUE_WIDTH-1:0]         req_aggressive_duration,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [simc_pkg::STATE_WIDTH-1:0]         rsp_state_out,
   output logic [simc_pkg::VALUE_WIDTH-1:0]         rsp_published_interval,
   output logic                                     rsp_publish,
   output logic                                     rsp_cancel_scan,
   output logic                                     rsp_scan_now,
   output logic [simc_pkg::COMMAND_WIDTH-1:0]       rsp_agent_command,
   output logic                                     rsp_schedule_auto,
   output logic                                     rsp_stop_auto_timer,
   output logic                                     rsp_start_aggr_timer,
   output logic [simc_pkg::VALUE_WIDTH-1:0]         rsp_timer_duration,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [simc_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [simc_pkg::VALUE_WIDTH-1:0]         csr_data
);
   import simc_pkg::*;

   localparam logic [INTERVAL_WIDTH-1:0] NO_SCAN = '1;

   typedef enum logic [STATE_WIDTH-1:0] {
      ST_INIT       = 3'd0,
      ST_OFF        = 3'd1,
      ST_ON         = 3'd2,
      ST_AUTO       = 3'd3,
      ST_AUTO_AGENT = 3'd4,
      ST_SENDING    = 3'd5
   } fsm_state_type;

   // configuration registers
   logic [SETTING_WIDTH-1:0]   setting_mode_ff;
   logic [VALUE_WIDTH-1:0]     fixed_interval_ff;
   logic                       scanning_enabled_ff;

   // input register
   logic                       s1_valid_ff;
   logic [EVENT_WIDTH-1:0]     s1_mode_ff;
   logic                       s1_status_ok_ff;
   logic [PRESENCE_WIDTH-1:0]  s1_presence_ff;
   logic [VALUE_WIDTH-1:0]     s1_auto_interval_ff;
   logic [VALUE_WIDTH-1:0]     s1_aggr_interval_ff;
   logic [VALUE_WIDTH-1:0]     s1_aggr_duration_ff;

   // controller state
   fsm_state_type              state_ff;
   target_type                 target_ff;
   logic [INTERVAL_WIDTH-1:0]  normal_ff;
   logic [INTERVAL_WIDTH-1:0]  aggr_ff;
   logic [INTERVAL_WIDTH-1:0]  used_ff;

   // result register
   logic                       rsp_valid_ff;
   logic [STATE_WIDTH-1:0]     rsp_state_ff;
   logic [VALUE_WIDTH-1:0]     rsp_published_ff;
   refresh_flags_type          rsp_flags_ff;
   logic [COMMAND_WIDTH-1:0]   rsp_command_ff;
   logic                       rsp_schedule_ff;
   logic                       rsp_stop_timer_ff;
   logic                       rsp_aggr_timer_ff;
   logic [VALUE_WIDTH-1:0]     rsp_duration_ff;

   // next values
   fsm_state_type              state_in;
   target_type                 target_in;
   logic [INTERVAL_WIDTH-1:0]  normal_in;
   logic [INTERVAL_WIDTH-1:0]  aggr_in;
   logic [INTERVAL_WIDTH-1:0]  used_in;
   refresh_flags_type          flags_in;
   logic [COMMAND_WIDTH-1:0]   command_in;
   logic                       schedule_in;
   logic                       stop_timer_in;
   logic                       aggr_timer_in;
   logic [VALUE_WIDTH-1:0]     duration_in;
   logic [VALUE_WIDTH-1:0]     published_in;

   logic                       advance;
   logic                       refresh_req;
   logic                       cancel_extra;
   logic                       go_off;
   logic                       go_on;
   logic                       go_auto;
   logic                       go_start;
   logic [INTERVAL_WIDTH-1:0]  auto_iv;
   logic [INTERVAL_WIDTH-1:0]  fixed_iv;
   logic [INTERVAL_WIDTH-1:0]  aggr_req;
   logic [INTERVAL_WIDTH-1:0]  auto_norm;
   logic [INTERVAL_WIDTH-1:0]  setting_norm;
   logic [INTERVAL_WIDTH-1:0]  used_calc;
   refresh_flags_type          calc_flags;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         setting_mode_ff <= SET_NEVER;
         fixed_interval_ff <= VALUE_WIDTH'(1);
         scanning_enabled_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SETTING_MODE: begin
               setting_mode_ff <= csr_data[SETTING_WIDTH-1:0];
            end
            CSR_FIXED_INTERVAL: begin
               fixed_interval_ff <= csr_data;
            end
            CSR_SCANNING_ENABLED: begin
               scanning_enabled_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            s1_valid_ff <= 1'b1;
            s1_mode_ff <= req_mode;
            s1_status_ok_ff <= req_status_ok;
            s1_presence_ff <= req_agent_presence;
            s1_auto_interval_ff <= req_auto_interval;
            s1_aggr_interval_ff <= req_aggressive_interval;
            s1_aggr_duration_ff <= req_aggressive_duration;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   assign auto_iv = s1_auto_interval_ff[INTERVAL_WIDTH-1:0];
   assign fixed_iv = fixed_interval_ff[INTERVAL_WIDTH-1:0];
   assign aggr_req = s1_aggr_interval_ff[INTERVAL_WIDTH-1:0];
   assign auto_norm = (auto_iv == '0) ? NO_SCAN : auto_iv;
   assign setting_norm = ((setting_mode_ff == SET_NEVER) || (fixed_iv == '0)) ? NO_SCAN
                                                                               : fixed_iv;

   // event decode
   always_comb begin
      state_in = state_ff;
      target_in = target_ff;
      normal_in = normal_ff;
      aggr_in = aggr_ff;
      refresh_req = 1'b0;
      cancel_extra = 1'b0;
      command_in = CMD_NONE;
      schedule_in = 1'b0;
      stop_timer_in = 1'b0;
      aggr_timer_in = 1'b0;
      duration_in = '0;
      go_off = 1'b0;
      go_on = 1'b0;
      go_auto = 1'b0;
      go_start = 1'b0;

      case (event_type'(s1_mode_ff))
         EV_INIT: begin
            state_in = (s1_presence_ff == PRES_STARTING) ? ST_INIT : ST_OFF;
         end
         EV_AGGR_START: begin
            if (aggr_req <= aggr_ff) begin
               aggr_in = aggr_req;
               aggr_timer_in = 1'b1;
               duration_in = s1_aggr_duration_ff;
               refresh_req = 1'b1;
            end
         end
         EV_AGGR_STOP: begin
            aggr_in = NO_SCAN;
            refresh_req = 1'b1;
         end
         EV_STARTUP_DONE: begin
            if (state_ff == ST_INIT) begin
               case (setting_mode_ff)
                  SET_NEVER: begin
                     go_off = 1'b1;
                  end
                  SET_AUTO: begin
                     if (s1_status_ok_ff && (s1_presence_ff == PRES_PRESENT)) begin
                        go_start = 1'b1;
                     end else begin
                        go_auto = 1'b1;
                     end
                  end
                  default: begin
                     go_on = 1'b1;
                  end
               endcase
            end
         end
         EV_SETTING_CHANGED: begin
            if (s1_presence_ff != PRES_STARTING) begin
               if (state_ff inside {ST_OFF, ST_ON}) begin
                  case (setting_mode_ff)
                     SET_NEVER: begin
                        go_off = (state_ff == ST_ON);
                     end
                     SET_AUTO: begin
                        go_start = (s1_presence_ff == PRES_PRESENT);
                        go_auto = (s1_presence_ff != PRES_PRESENT);
                     end
                     default: begin
                        go_on = 1'b1;
                     end
                  endcase
               end else if (state_ff == ST_AUTO) begin
                  if (setting_mode_ff == SET_AUTO) begin
                     go_auto = 1'b1;
                  end else begin
                     stop_timer_in = 1'b1;
                     go_off = (setting_mode_ff == SET_NEVER);
                     go_on = (setting_mode_ff != SET_NEVER);
                  end
               end else if (state_ff == ST_AUTO_AGENT) begin
                  if (setting_mode_ff == SET_NEVER) begin
                     state_in = ST_SENDING;
                     target_in = PT_OFF;
                     command_in = CMD_STOP;
                     cancel_extra = 1'b1;
                  end else if (setting_mode_ff != SET_AUTO) begin
                     state_in = ST_SENDING;
                     target_in = PT_ON;
                     command_in = CMD_STOP;
                  end
               end
            end
         end
         EV_AGENT_INTERVAL: begin
            if (state_ff == ST_AUTO_AGENT) begin
               normal_in = auto_norm;
               refresh_req = 1'b1;
            end
         end
         EV_COMMAND_DONE: begin
            if (state_ff == ST_SENDING) begin
               case (target_ff)
                  PT_OFF: begin
                     go_off = 1'b1;
                  end
                  PT_ON: begin
                     go_on = 1'b1;
                  end
                  PT_AUTO_AGENT: begin
                     if (s1_status_ok_ff) begin
                        state_in = ST_AUTO_AGENT;
                        normal_in = auto_norm;
                        refresh_req = 1'b1;
                     end else begin
                        go_auto = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase

      if (go_off) begin
         state_in = ST_OFF;
         normal_in = NO_SCAN;
         refresh_req = 1'b1;
      end
      if (go_on) begin
         state_in = ST_ON;
         normal_in = setting_norm;
         refresh_req = 1'b1;
      end
      if (go_auto) begin
         state_in = ST_AUTO;
         schedule_in = 1'b1;
         normal_in = auto_norm;
         refresh_req = 1'b1;
      end
      if (go_start) begin
         state_in = ST_SENDING;
         target_in = PT_AUTO_AGENT;
         command_in = CMD_START;
      end
   end

   simc_refresh #(
      .INTERVAL_WIDTH (INTERVAL_WIDTH)
   ) u_refresh (
      .scanning_enabled (scanning_enabled_ff),
      .aggr_interval    (aggr_in),
      .normal_interval  (normal_in),
      .old_used         (used_ff),
      .new_used         (used_calc),
      .flags            (calc_flags)
   );

   always_comb begin
      if (refresh_req) begin
         used_in = used_calc;
         flags_in = calc_flags;
      end else begin
         used_in = used_ff;
         flags_in = '0;
      end
      flags_in.cancel_scan = flags_in.cancel_scan | cancel_extra;
   end

   assign published_in = (used_in == NO_SCAN) ? '0 : VALUE_WIDTH'(used_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         target_ff <= PT_NONE;
         normal_ff <= NO_SCAN;
         aggr_ff <= NO_SCAN;
         used_ff <= NO_SCAN;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
            target_ff <= target_in;
            normal_ff <= normal_in;
            aggr_ff <= aggr_in;
            used_ff <= used_in;
            rsp_valid_ff <= 1'b1;
            rsp_state_ff <= state_in;
            rsp_published_ff <= published_in;
            rsp_flags_ff <= flags_in;
            rsp_command_ff <= command_in;
            rsp_schedule_ff <= schedule_in;
            rsp_stop_timer_ff <= stop_timer_in;
            rsp_aggr_timer_ff <= aggr_timer_in;
            rsp_duration_ff <= duration_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_state_out = rsp_state_ff;
   assign rsp_published_interval = rsp_published_ff;
   assign rsp_publish = rsp_flags_ff.publish;
   assign rsp_cancel_scan = rsp_flags_ff.cancel_scan;
   assign rsp_scan_now = rsp_flags_ff.scan_now;
   assign rsp_agent_command = rsp_command_ff;
   assign rsp_schedule_auto = rsp_schedule_ff;
   assign rsp_stop_auto_timer = rsp_stop_timer_ff;
   assign rsp_start_aggr_timer = rsp_aggr_timer_ff;
   assign rsp_timer_duration = rsp_duration_ff;

   // checks
   a_scan_now_cancels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_scan_now || rsp_cancel_scan))
      else $error("scan now without cancel");

   a_duration_with_timer: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_start_aggr_timer) |-> (rsp_timer_duration == '0))
      else $error("timer duration without timer restart");

   a_sending_has_target: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SENDING) |-> (target_ff != PT_NONE))
      else $error("sending state with no pending target");

   a_start_in_sending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_agent_command == CMD_START)) |-> (rsp_state_out == ST_SENDING))
      else $error("agent start outside sending state");

endmodule
